FILE: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
	localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BITS_PER_BYTE - 1);

	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_STOP     = 3'd1,
		OP_WRITE    = 3'd2,
		OP_READ     = 3'd3,
		OP_SEND_ACK = 3'd4,
		OP_READ_ACK = 3'd5
	} op_t;

	// Step index of the final phase within one bit slot.
	localparam logic [1:0] STEP_LAST_START = 2'd3;
	localparam logic [1:0] STEP_LAST_OTHER = 2'd2;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       ack_level;
		logic [7:0] line_bits;
		logic [1:0] last_step;
		logic       multi_bit;
	} cmd_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] read_value;
		logic       ack_seen;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/i2cm_fifo.sv
// Two-entry first-in first-out queue with show-ahead read data.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_fifo #(
	parameter int WIDTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/i2cm_front.sv
// Command decoder: classifies an incoming word and builds its queue descriptor.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
	input  wire logic        push,
	input  wire logic        q_full,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  data_byte,
	input  wire logic        ack_level,
	input  wire logic [7:0]  line_bits,
	output logic             q_wr,
	output i2cm_pkg::cmd_t   q_word
);

	logic known;

	always_comb begin
		known                = 1'b1;
		q_word.op            = i2cm_pkg::OP_START;
		q_word.data_byte     = data_byte;
		q_word.ack_level     = ack_level;
		q_word.line_bits     = line_bits;
		q_word.last_step     = i2cm_pkg::STEP_LAST_OTHER;
		q_word.multi_bit     = 1'b0;
		unique case (command)
			3'd0: begin
				q_word.op        = i2cm_pkg::OP_START;
				q_word.last_step = i2cm_pkg::STEP_LAST_START;
			end
			3'd1: q_word.op = i2cm_pkg::OP_STOP;
			3'd2: begin
				q_word.op        = i2cm_pkg::OP_WRITE;
				q_word.multi_bit = 1'b1;
			end
			3'd3: begin
				q_word.op        = i2cm_pkg::OP_READ;
				q_word.multi_bit = 1'b1;
			end
			3'd4: q_word.op = i2cm_pkg::OP_SEND_ACK;
			3'd5: q_word.op = i2cm_pkg::OP_READ_ACK;
			default: known = 1'b0;
		endcase
	end

	// Unused codes are taken off the port but never reach the sequencer.
	assign q_wr = push && !q_full && known;

endmodule

`default_nettype wire

FILE: rtl/i2cm_back.sv
// Pin sequencer: plays one queued command out as SCL/SDA phases into a result queue.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire i2cm_pkg::cmd_t cmd,
	output logic                cmd_pop,
	input  wire logic           res_pop,
	output logic                res_empty,
	output i2cm_pkg::res_t      res
);

	logic                             scl_q;
	logic                             sda_q;
	logic [1:0]                       step_q;
	logic [i2cm_pkg::BIT_IDX_W-1:0]   bit_q;
	logic                             res_full;
	logic                             adv;
	logic                             step_wrap;
	logic                             fin;
	i2cm_pkg::res_t                   phase;
	logic [$bits(i2cm_pkg::res_t)-1:0] res_bits;

	assign adv       = cmd_valid && !res_full;
	assign step_wrap = (step_q == cmd.last_step);
	assign fin       = step_wrap && (!cmd.multi_bit || (bit_q == i2cm_pkg::BIT_LAST));
	assign cmd_pop   = adv && fin;

	always_comb begin
		phase.scl        = scl_q;
		phase.sda        = sda_q;
		phase.read_value = 8'd0;
		phase.ack_seen   = 1'b0;
		phase.last       = fin;
		unique case (cmd.op)
			i2cm_pkg::OP_START: begin
				unique case (step_q)
					2'd0:    phase.sda = 1'b1;
					2'd1:    phase.scl = 1'b1;
					2'd2:    phase.sda = 1'b0;
					default: phase.scl = 1'b0;
				endcase
			end
			i2cm_pkg::OP_STOP: begin
				unique case (step_q)
					2'd0:    phase.sda = 1'b0;
					2'd1:    phase.scl = 1'b1;
					default: phase.sda = 1'b1;
				endcase
			end
			default: begin
				// Byte and ack slots share one shape: set SDA, raise SCL, drop SCL.
				unique case (step_q)
					2'd0: begin
						unique case (cmd.op)
							i2cm_pkg::OP_WRITE:    phase.sda = cmd.data_byte[~bit_q];
							i2cm_pkg::OP_SEND_ACK: phase.sda = cmd.ack_level;
							default:               phase.sda = 1'b1;
						endcase
					end
					2'd1:    phase.scl = 1'b1;
					default: phase.scl = 1'b0;
				endcase
				// Every bit of the byte is sampled, so the assembled value is the line word.
				if (fin && cmd.op == i2cm_pkg::OP_READ) begin
					phase.read_value = cmd.line_bits;
				end
				if (fin && cmd.op == i2cm_pkg::OP_READ_ACK) begin
					phase.ack_seen = cmd.line_bits[7];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			step_q <= 2'd0;
			bit_q  <= '0;
		end else if (adv) begin
			scl_q <= phase.scl;
			sda_q <= phase.sda;
			if (fin) begin
				step_q <= 2'd0;
				bit_q  <= '0;
			end else if (step_wrap) begin
				step_q <= 2'd0;
				bit_q  <= bit_q + i2cm_pkg::BIT_IDX_W'(1);
			end else begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	i2cm_fifo #(
		.WIDTH($bits(i2cm_pkg::res_t))
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (adv),
		.wr_data(phase),
		.full   (res_full),
		.rd_en  (res_pop),
		.rd_data(res_bits),
		.empty  (res_empty)
	);

	assign res = i2cm_pkg::res_t'(res_bits);

endmodule

`default_nettype wire

FILE: rtl/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer.
`timescale 1ns / 1ps
`default_nettype none

// I2C master pin sequencer. Each command word pushed in (start, stop, write byte,
// read byte, send ack, read ack) comes out as a series of result words, one per
// pin write, giving SCL and SDA after that write; the final word of a command has
// last set and carries the read byte or the sampled ack. The sequencer emits one
// phase per clock cycle while a command is queued and the result queue has room;
// a start gives 4 phases, a stop or either ack 3, and a byte 24 (three phases for
// each of 8 bits); that phase rate sets the throughput. A two-entry command queue
// sits in front of the sequencer and a two-entry result queue behind it, so the
// next command is taken while the current one plays out and a stalled pop only
// holds the sequencer. Read data is not taken from a pin: line_bits supplies the
// SDA level seen at each SCL-high sample, bit 7 first. Command codes 6 and 7 are
// accepted and dropped without any result. Pin levels start released high after
// reset and otherwise carry over between commands.

module i2c_master_bit_sequencer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [2:0] command,
	input  wire logic [7:0] data_byte,
	input  wire logic       ack_level,
	input  wire logic [7:0] line_bits,
	output logic            empty,
	input  wire logic       pop,
	output logic            scl,
	output logic            sda,
	output logic [7:0]      read_value,
	output logic            ack_seen,
	output logic            last
);

	logic                              q_wr;
	i2cm_pkg::cmd_t                    q_word;
	logic                              q_empty;
	logic                              q_pop;
	logic [$bits(i2cm_pkg::cmd_t)-1:0] q_head_bits;
	i2cm_pkg::cmd_t                    q_head;
	i2cm_pkg::res_t                    res;

	i2cm_front u_front (
		.push     (push),
		.q_full   (full),
		.command  (command),
		.data_byte(data_byte),
		.ack_level(ack_level),
		.line_bits(line_bits),
		.q_wr     (q_wr),
		.q_word   (q_word)
	);

	i2cm_fifo #(
		.WIDTH($bits(i2cm_pkg::cmd_t))
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_data(q_word),
		.full   (full),
		.rd_en  (q_pop),
		.rd_data(q_head_bits),
		.empty  (q_empty)
	);

	assign q_head = i2cm_pkg::cmd_t'(q_head_bits);

	i2cm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(!q_empty),
		.cmd      (q_head),
		.cmd_pop  (q_pop),
		.res_pop  (pop),
		.res_empty(empty),
		.res      (res)
	);

	assign scl        = res.scl;
	assign sda        = res.sda;
	assign read_value = res.read_value;
	assign ack_seen   = res.ack_seen;
	assign last       = res.last;

endmodule

`default_nettype wire

FILE: rtl/i2cm_checker.sv
// Port-level checker for the I2C master bit sequencer and its bind.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic       scl,
	input wire logic       sda,
	input wire logic [7:0] read_value,
	input wire logic       ack_seen,
	input wire logic       last
);

	// A waiting word must stay put until it is popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable({scl, sda, read_value, ack_seen, last})))
		else $error("result word changed or vanished while stalled");

	a_rv_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && read_value != 8'd0) |-> last)
		else $error("read byte shown on a phase that is not final");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ack_seen) |-> last)
		else $error("sampled ack shown on a phase that is not final");

	// Every command ends with SCL low, except stop, which ends with both lines high.
	a_end_level: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (!scl || sda))
		else $error("command ended with SCL high and SDA low");

endmodule

bind i2c_master_bit_sequencer_core i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.scl       (scl),
	.sda       (sda),
	.read_value(read_value),
	.ack_seen  (ack_seen),
	.last      (last)
);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the I2C master bit sequencer core.
`timescale 1ns / 1ps

// Tracks the SCL/SDA levels of the bus and keeps the phase words each accepted
// command should produce, oldest first.
class pin_phase_board;
	localparam logic [7:0] TOP_BIT = 8'h80;

	i2cm_pkg::res_t phase_queue[$];
	logic           scl_lvl;
	logic           sda_lvl;
	int             errors;

	function new();
		scl_lvl = 1'b1;
		sda_lvl = 1'b1;
		errors  = 0;
	endfunction

	function void add_phase(logic [7:0] rv, logic ack, logic fin);
		i2cm_pkg::res_t r;
		r.scl        = scl_lvl;
		r.sda        = sda_lvl;
		r.read_value = rv;
		r.ack_seen   = ack;
		r.last       = fin;
		phase_queue.push_back(r);
	endfunction

	function void note_command(logic [2:0] cmd, logic [7:0] tx, logic ackb,
			logic [7:0] line_v);
		logic [7:0] acc;
		logic [7:0] mask;
		acc = '0;
		case (cmd)
			i2cm_pkg::OP_START: begin
				sda_lvl = 1'b1; add_phase(8'h00, 1'b0, 1'b0);
				scl_lvl = 1'b1; add_phase(8'h00, 1'b0, 1'b0);
				sda_lvl = 1'b0; add_phase(8'h00, 1'b0, 1'b0);
				scl_lvl = 1'b0; add_phase(8'h00, 1'b0, 1'b1);
			end
			i2cm_pkg::OP_STOP: begin
				sda_lvl = 1'b0; add_phase(8'h00, 1'b0, 1'b0);
				scl_lvl = 1'b1; add_phase(8'h00, 1'b0, 1'b0);
				sda_lvl = 1'b1; add_phase(8'h00, 1'b0, 1'b1);
			end
			i2cm_pkg::OP_WRITE: begin
				for (int i = 0; i < i2cm_pkg::BITS_PER_BYTE; i++) begin
					mask = TOP_BIT >> i;
					sda_lvl = |(tx & mask);
					add_phase(8'h00, 1'b0, 1'b0);
					scl_lvl = 1'b1;
					add_phase(8'h00, 1'b0, 1'b0);
					scl_lvl = 1'b0;
					add_phase(8'h00, 1'b0, i == i2cm_pkg::BITS_PER_BYTE - 1);
				end
			end
			i2cm_pkg::OP_READ: begin
				for (int i = 0; i < i2cm_pkg::BITS_PER_BYTE; i++) begin
					mask = TOP_BIT >> i;
					sda_lvl = 1'b1;
					add_phase(8'h00, 1'b0, 1'b0);
					scl_lvl = 1'b1;
					acc = acc | (line_v & mask);
					add_phase(8'h00, 1'b0, 1'b0);
					scl_lvl = 1'b0;
					if (i == i2cm_pkg::BITS_PER_BYTE - 1)
						add_phase(acc, 1'b0, 1'b1);
					else
						add_phase(8'h00, 1'b0, 1'b0);
				end
			end
			i2cm_pkg::OP_SEND_ACK: begin
				sda_lvl = ackb; add_phase(8'h00, 1'b0, 1'b0);
				scl_lvl = 1'b1; add_phase(8'h00, 1'b0, 1'b0);
				scl_lvl = 1'b0; add_phase(8'h00, 1'b0, 1'b1);
			end
			i2cm_pkg::OP_READ_ACK: begin
				sda_lvl = 1'b1; add_phase(8'h00, 1'b0, 1'b0);
				scl_lvl = 1'b1; add_phase(8'h00, 1'b0, 1'b0);
				scl_lvl = 1'b0; add_phase(8'h00, |(line_v & TOP_BIT), 1'b1);
			end
			default: ;
		endcase
	endfunction

	function int pending();
		return phase_queue.size();
	endfunction

	function void compare(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	function void check_phase(i2cm_pkg::res_t got);
		i2cm_pkg::res_t want;
		if (phase_queue.size() == 0) begin
			errors++;
			$display("%0t: phase word expected none actual scl %0b sda %0b last %0b",
				$time, got.scl, got.sda, got.last);
			return;
		end
		want = phase_queue.pop_front();
		compare("scl", 8'(want.scl), 8'(got.scl));
		compare("sda", 8'(want.sda), 8'(got.sda));
		compare("read_value", want.read_value, got.read_value);
		compare("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
		compare("last", 8'(want.last), 8'(got.last));
	endfunction
endclass

module tb;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int RANDOM_WORDS = 330;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 600000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic [2:0] command = '0;
	logic [7:0] data_byte = '0;
	logic       ack_level = 1'b0;
	logic [7:0] line_bits = '0;
	logic       full;
	logic       empty;
	logic       scl;
	logic       sda;
	logic [7:0] read_value;
	logic       ack_seen;
	logic       last;

	pin_phase_board board = new();
	int  words_sent = 0;
	int  cycle_count = 0;
	int  idle_odds = 0;
	int  stall_odds = 0;
	bit  calm = 1'b0;

	i2c_master_bit_sequencer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.data_byte  (data_byte),
		.ack_level  (ack_level),
		.line_bits  (line_bits),
		.empty      (empty),
		.pop        (pop),
		.scl        (scl),
		.sda        (sda),
		.read_value (read_value),
		.ack_seen   (ack_seen),
		.last       (last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_word(input logic [2:0] cmd, input logic [7:0] tx,
			input logic ackb, input logic [7:0] line_v);
		int gap;
		gap = 0;
		if (!calm && idle_odds != 0 && $urandom_range(0, 7) < idle_odds)
			gap = $urandom_range(1, 12);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		command   <= cmd;
		data_byte <= tx;
		ack_level <= ackb;
		line_bits <= line_v;
		do @(posedge clk); while (full !== 1'b0);
		board.note_command(cmd, tx, ackb, line_v);
		if (cmd <= i2cm_pkg::OP_READ_ACK)
			words_sent++;
	endtask

	task automatic send_op(input logic [2:0] cmd);
		send_word(cmd, 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// One well-formed transfer: start, address, ack, a few data bytes, and
	// usually a stop; without the stop the next transfer is a repeated start.
	task automatic play_transfer();
		logic [7:0] addr;
		int         n;
		addr = 8'($urandom);
		n = $urandom_range(1, 4);
		send_op(i2cm_pkg::OP_START);
		send_word(i2cm_pkg::OP_WRITE, addr, 1'($urandom), 8'($urandom));
		send_op(i2cm_pkg::OP_READ_ACK);
		for (int k = 0; k < n; k++) begin
			if (addr[0]) begin
				send_op(i2cm_pkg::OP_READ);
				send_word(i2cm_pkg::OP_SEND_ACK, 8'($urandom), k == n - 1, 8'($urandom));
			end else begin
				send_op(i2cm_pkg::OP_WRITE);
				send_op(i2cm_pkg::OP_READ_ACK);
			end
		end
		if ($urandom_range(0, 3) != 0)
			send_op(i2cm_pkg::OP_STOP);
	endtask

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (!calm && stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (empty === 1'b0)
				board.check_phase('{scl: scl, sda: sda, read_value: read_value,
					ack_seen: ack_seen, last: last});
		end
	end

	initial begin
		bit paused;
		paused = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: extreme bytes and line levels, both ack levels,
		// spare codes, and a stop right after a stop.
		send_op(i2cm_pkg::OP_START);
		send_word(i2cm_pkg::OP_WRITE, 8'h00, 1'b1, 8'hFF);
		send_word(i2cm_pkg::OP_READ_ACK, 8'hFF, 1'b1, 8'h00);
		send_word(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, 8'h00);
		send_word(i2cm_pkg::OP_READ_ACK, 8'h00, 1'b0, 8'hFF);
		send_word(i2cm_pkg::OP_WRITE, 8'hA5, 1'b1, 8'h5A);
		send_word(i2cm_pkg::OP_READ, 8'hFF, 1'b1, 8'h00);
		send_word(i2cm_pkg::OP_SEND_ACK, 8'h00, 1'b0, 8'hFF);
		send_word(i2cm_pkg::OP_READ, 8'h00, 1'b0, 8'hFF);
		send_word(i2cm_pkg::OP_SEND_ACK, 8'hFF, 1'b1, 8'h00);
		send_word(i2cm_pkg::OP_READ, 8'h3C, 1'b0, 8'h5A);
		send_word(i2cm_pkg::OP_READ_ACK, 8'h00, 1'b0, 8'h80);
		send_word(i2cm_pkg::OP_READ_ACK, 8'hFF, 1'b1, 8'h7F);
		send_op(i2cm_pkg::OP_STOP);
		send_word(CMD_SPARE_LO, 8'hFF, 1'b1, 8'hFF);
		send_word(CMD_SPARE_HI, 8'h00, 1'b0, 8'h00);
		send_op(i2cm_pkg::OP_START);
		send_word(i2cm_pkg::OP_WRITE, 8'h80, 1'b0, 8'h01);
		send_word(i2cm_pkg::OP_WRITE, 8'h01, 1'b1, 8'h80);
		send_op(i2cm_pkg::OP_STOP);
		send_op(i2cm_pkg::OP_STOP);

		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			idle_odds  = $urandom_range(0, 3);
			stall_odds = $urandom_range(0, 3);
			if (words_sent >= RANDOM_WORDS - 60)
				calm = 1'b1;
			if (!paused && words_sent >= RANDOM_WORDS / 2) begin
				push <= 1'b0;
				wait_drained();
				paused = 1'b1;
			end
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3))
					send_word(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
						8'($urandom));
			end else begin
				play_transfer();
			end
		end
		push <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
